// ===== rtl/core/seg_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_pkg
// Shared types and constants of the segment intersection classifier: result
// codes, the endpoint difference vectors and the product pairings.
// ----------------------------------------------------------------------------
package seg_pkg;

  // Coordinates of one request: S, E (first segment), P, Q (second segment)
  localparam int NUM_COORD = 8;
  localparam int PT_S      = 0;
  localparam int PT_E      = 1;
  localparam int PT_P      = 2;
  localparam int PT_Q      = 3;

  // Difference vectors, each "to - from"
  localparam int VEC_ES   = 0;  // E - S
  localparam int VEC_PS   = 1;  // P - S
  localparam int VEC_QS   = 2;  // Q - S
  localparam int VEC_QP   = 3;  // Q - P
  localparam int VEC_SP   = 4;  // S - P
  localparam int VEC_EP   = 5;  // E - P
  localparam int VEC_SQ   = 6;  // S - Q
  localparam int VEC_EQ   = 7;  // E - Q
  localparam int NUM_VEC  = 8;
  localparam int NUM_DIFF = 2 * NUM_VEC;

  localparam int VEC_TO   [NUM_VEC] = '{PT_E, PT_P, PT_Q, PT_Q, PT_S, PT_E, PT_S, PT_E};
  localparam int VEC_FROM [NUM_VEC] = '{PT_S, PT_S, PT_S, PT_P, PT_P, PT_P, PT_Q, PT_Q};

  // Vector pairs: first four are cross products, last four are dot products.
  // Cross k and dot k belong together: the endpoint tested by cross k is the
  // one whose extent check is dot k (P, Q, S, E in that order).
  localparam int NUM_CROSS = 4;
  localparam int NUM_PAIR  = 2 * NUM_CROSS;
  localparam int NUM_PROD  = 2 * NUM_PAIR;

  localparam int PAIR_U [NUM_PAIR] = '{VEC_ES, VEC_ES, VEC_QP, VEC_QP,
                                       VEC_SP, VEC_SQ, VEC_PS, VEC_EP};
  localparam int PAIR_V [NUM_PAIR] = '{VEC_PS, VEC_QS, VEC_SP, VEC_EP,
                                       VEC_EP, VEC_EQ, VEC_QS, VEC_EQ};

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_TOUCH = 2'd1,
    CLS_CROSS = 2'd2
  } cls_t;

  // Sign information handed from the sum stage to the classifier
  typedef struct packed {
    logic [NUM_CROSS-1:0] cross_neg;
    logic [NUM_CROSS-1:0] cross_zero;
    logic [NUM_CROSS-1:0] dot_le0;
  } seg_flags_t;

endpackage

// ===== rtl/core/seg_if.sv =====
// ----------------------------------------------------------------------------
// seg_if
// Valid/ready channels of the classifier: segment pair requests in, class
// results out.
// ----------------------------------------------------------------------------
interface seg_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] first_start_x;
  logic [COORD_WIDTH-1:0] first_start_y;
  logic [COORD_WIDTH-1:0] first_end_x;
  logic [COORD_WIDTH-1:0] first_end_y;
  logic [COORD_WIDTH-1:0] second_start_x;
  logic [COORD_WIDTH-1:0] second_start_y;
  logic [COORD_WIDTH-1:0] second_end_x;
  logic [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface seg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] crossing_class;

  modport source (output valid, crossing_class, input ready);
  modport sink   (input valid, crossing_class, output ready);
endinterface

// ===== rtl/core/seg_diff.sv =====
// ----------------------------------------------------------------------------
// seg_diff
// Stage 1: sign-extend the coordinates and register all endpoint differences.
// ----------------------------------------------------------------------------
module seg_diff
  import seg_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [NUM_COORD-1:0][CW-1:0]        coords,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [NUM_DIFF-1:0][CW:0]           diffs
);

  logic                      valid_r;
  logic [NUM_DIFF-1:0][CW:0] diffs_r;
  logic [NUM_DIFF-1:0][CW:0] diffs_nxt;

  // Form each vector as "to - from" on both axes
  for (genvar v = 0; v < NUM_VEC; v++) begin : g_vec
    for (genvar a = 0; a < 2; a++) begin : g_axis
      localparam int TI = 2 * VEC_TO[v] + a;
      localparam int FI = 2 * VEC_FROM[v] + a;
      assign diffs_nxt[2*v+a] = {coords[TI][CW-1], coords[TI]}
                              - {coords[FI][CW-1], coords[FI]};
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Advance when the next stage takes the current request or the slot is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      diffs_r <= diffs_nxt;
    end
  end

  assign out_valid = valid_r;
  assign diffs     = diffs_r;

endmodule

// ===== rtl/core/seg_prod.sv =====
// ----------------------------------------------------------------------------
// seg_prod
// Stage 2: register the sixteen partial products of the cross and dot terms.
// ----------------------------------------------------------------------------
module seg_prod
  import seg_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [NUM_DIFF-1:0][CW:0]           diffs,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [NUM_PROD-1:0][2*CW+1:0]       prods
);

  localparam int PW = 2 * CW + 2;

  logic                        valid_r;
  logic [NUM_PROD-1:0][PW-1:0] prods_r;
  logic [NUM_PROD-1:0][PW-1:0] prods_nxt;

  // Cross pairs take ux*vy and uy*vx, dot pairs take ux*vx and uy*vy;
  // operands are sign-extended to the full product width first
  for (genvar k = 0; k < NUM_PAIR; k++) begin : g_pair
    localparam int UX = 2 * PAIR_U[k];
    localparam int UY = 2 * PAIR_U[k] + 1;
    localparam int VX = 2 * PAIR_V[k];
    localparam int VY = 2 * PAIR_V[k] + 1;
    if (k < NUM_CROSS) begin : g_cross
      assign prods_nxt[2*k]   = $signed({{(CW+1){diffs[UX][CW]}}, diffs[UX]})
                              * $signed({{(CW+1){diffs[VY][CW]}}, diffs[VY]});
      assign prods_nxt[2*k+1] = $signed({{(CW+1){diffs[UY][CW]}}, diffs[UY]})
                              * $signed({{(CW+1){diffs[VX][CW]}}, diffs[VX]});
    end else begin : g_dot
      assign prods_nxt[2*k]   = $signed({{(CW+1){diffs[UX][CW]}}, diffs[UX]})
                              * $signed({{(CW+1){diffs[VX][CW]}}, diffs[VX]});
      assign prods_nxt[2*k+1] = $signed({{(CW+1){diffs[UY][CW]}}, diffs[UY]})
                              * $signed({{(CW+1){diffs[VY][CW]}}, diffs[VY]});
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prods_r <= prods_nxt;
    end
  end

  assign out_valid = valid_r;
  assign prods     = prods_r;

endmodule

// ===== rtl/core/seg_sign.sv =====
// ----------------------------------------------------------------------------
// seg_sign
// Stage 3: combine partial products into cross and dot values and register
// only their sign information.
// ----------------------------------------------------------------------------
module seg_sign
  import seg_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [NUM_PROD-1:0][2*CW+1:0]       prods,
  output logic                                out_valid,
  input  logic                                out_ready,
  output seg_flags_t                          flags
);

  localparam int PW = 2 * CW + 2;
  localparam int SW = PW + 1;

  logic                 valid_r;
  seg_flags_t           flags_r;
  logic [NUM_CROSS-1:0] neg_nxt;
  logic [NUM_CROSS-1:0] zero_nxt;
  logic [NUM_CROSS-1:0] le0_nxt;

  for (genvar k = 0; k < NUM_CROSS; k++) begin : g_term
    logic [SW-1:0] cross_sum;
    logic [SW-1:0] dot_sum;
    localparam int CA = 2 * k;
    localparam int CB = 2 * k + 1;
    localparam int DA = 2 * (NUM_CROSS + k);
    localparam int DB = 2 * (NUM_CROSS + k) + 1;

    // Cross is a difference of products, dot is a sum
    assign cross_sum = {prods[CA][PW-1], prods[CA]} - {prods[CB][PW-1], prods[CB]};
    assign dot_sum   = {prods[DA][PW-1], prods[DA]} + {prods[DB][PW-1], prods[DB]};

    assign neg_nxt[k]  = cross_sum[SW-1];
    assign zero_nxt[k] = (cross_sum == '0);
    assign le0_nxt[k]  = dot_sum[SW-1] || (dot_sum == '0);
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      flags_r.cross_neg  <= neg_nxt;
      flags_r.cross_zero <= zero_nxt;
      flags_r.dot_le0    <= le0_nxt;
    end
  end

  assign out_valid = valid_r;
  assign flags     = flags_r;

endmodule

// ===== rtl/core/segment_intersection_classifier.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier
// Classifies two integer segments as proper crossing, touching/overlap or no
// contact, using four cross-product signs and dot-product extent checks.
// ----------------------------------------------------------------------------
// Pipeline: four register stages, differences (loaded at the accepting edge),
//   then products, sums/signs and class.
// Throughput: one request per cycle; every stage holds its request under
//   backpressure and takes a new one as soon as its slot frees.
// Reset: rst_n synchronous active low clears all stage valid bits.
// ----------------------------------------------------------------------------
module segment_intersection_classifier
  import seg_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  seg_in_if.sink   in_seg,
  seg_out_if.source out_seg
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW + 2;

  logic [NUM_COORD-1:0][CW-1:0] coords;
  logic [NUM_DIFF-1:0][CW:0]    diffs;
  logic [NUM_PROD-1:0][PW-1:0]  prods;
  seg_flags_t                   flags;

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;

  logic out_valid_r;
  cls_t cls_r;
  cls_t cls_nxt;
  logic pair_12_opp;
  logic pair_34_opp;
  logic touch;

  // Gather coordinates in S, E, P, Q order
  assign coords[2*PT_S]   = in_seg.first_start_x;
  assign coords[2*PT_S+1] = in_seg.first_start_y;
  assign coords[2*PT_E]   = in_seg.first_end_x;
  assign coords[2*PT_E+1] = in_seg.first_end_y;
  assign coords[2*PT_P]   = in_seg.second_start_x;
  assign coords[2*PT_P+1] = in_seg.second_start_y;
  assign coords[2*PT_Q]   = in_seg.second_end_x;
  assign coords[2*PT_Q+1] = in_seg.second_end_y;

  seg_diff #(.CW(CW)) u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .coords    (coords),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .diffs     (diffs)
  );

  seg_prod #(.CW(CW)) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .diffs     (diffs),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .prods     (prods)
  );

  seg_sign #(.CW(CW)) u_sign (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .prods     (prods),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .flags     (flags)
  );

  // Classify: both sign pairs strictly opposite gives a crossing; otherwise
  // any collinear endpoint inside the other segment's extent gives a touch
  always_comb begin
    pair_12_opp = !flags.cross_zero[0] && !flags.cross_zero[1]
               && (flags.cross_neg[0] ^ flags.cross_neg[1]);
    pair_34_opp = !flags.cross_zero[2] && !flags.cross_zero[3]
               && (flags.cross_neg[2] ^ flags.cross_neg[3]);
    touch       = |(flags.cross_zero & flags.dot_le0);
    if (pair_12_opp && pair_34_opp) begin
      cls_nxt = CLS_CROSS;
    end else if (touch) begin
      cls_nxt = CLS_TOUCH;
    end else begin
      cls_nxt = CLS_NONE;
    end
  end

  assign s3_ready = !out_valid_r || out_seg.ready;

  // Output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_seg.valid          = out_valid_r;
  assign out_seg.crossing_class = cls_r;

  // A full pipeline is the only reason to refuse a request
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_seg.ready |-> (s1_valid && s2_valid && s3_valid && out_valid_r))
    else $error("input stalled while a pipeline slot is free");

  // Any collinear endpoint rules out a proper crossing
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && s3_ready && (flags.cross_zero != '0)) |=> (cls_r != CLS_CROSS))
    else $error("crossing reported with a zero cross sign");

  // Touch needs a collinear endpoint within extent
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && s3_ready && ((flags.cross_zero & flags.dot_le0) == '0))
      |=> (cls_r != CLS_TOUCH))
    else $error("touch reported without a collinear endpoint in extent");

  // The unused code never leaves the block
  assert property (@(posedge clk) disable iff (!rst_n)
    out_seg.valid |-> (out_seg.crossing_class != 2'd3))
    else $error("invalid class code on output");

endmodule

// ===== bench/segment_intersection_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classifier_tb
// Self-checking bench for the segment intersection classifier. Segment pair
// requests go in through the valid/ready channel with random gaps, and results
// come back under random stalls. Each result is compared with the class that a
// behavioral model of the crossing test computes. Stimulus starts with
// directed corner cases (extreme coordinates, crossings, touches, collinear
// and degenerate segments) and continues with random pairs of several shapes.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_tb
  import seg_pkg::*;
();

  localparam int CW         = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 1000;
  localparam int TAIL_WAIT  = 8;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  logic clk;
  logic rst_n;

  seg_in_if #(.COORD_WIDTH(CW)) in_seg_bus ();
  seg_out_if                    out_seg_bus ();

  segment_intersection_classifier #(
    .COORD_WIDTH(CW)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg_bus),
    .out_seg (out_seg_bus)
  );

  cls_t expected_class_q[$];
  int   err_count;
  int   idle_cycles;
  bit   steady_flow;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Crossing model
  // --------------------------------------------------------------------------

  // Sign of (b-a) x (c-a)
  function automatic int turn_sign(input longint ax, ay, bx, by, cx, cy);
    longint cr;
    cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
  endfunction

  // True when p lies within the extent of a..b: (a-p).(b-p) <= 0
  function automatic bit in_span(input longint px, py, ax, ay, bx, by);
    return ((ax - px) * (bx - px) + (ay - py) * (by - py)) <= 0;
  endfunction

  function automatic cls_t classify_pair(input seg_pair_t p);
    longint sx, sy, ex, ey, px, py, qx, qy;
    int     d1, d2, d3, d4;
    sx = p.first_start_x;  sy = p.first_start_y;
    ex = p.first_end_x;    ey = p.first_end_y;
    px = p.second_start_x; py = p.second_start_y;
    qx = p.second_end_x;   qy = p.second_end_y;
    d1 = turn_sign(sx, sy, ex, ey, px, py);
    d2 = turn_sign(sx, sy, ex, ey, qx, qy);
    d3 = turn_sign(px, py, qx, qy, sx, sy);
    d4 = turn_sign(px, py, qx, qy, ex, ey);
    if (d1 * d2 == -1 && d3 * d4 == -1)
      return CLS_CROSS;
    if ((d1 == 0 && in_span(px, py, sx, sy, ex, ey)) ||
        (d2 == 0 && in_span(qx, qy, sx, sy, ex, ey)) ||
        (d3 == 0 && in_span(sx, sy, px, py, qx, qy)) ||
        (d4 == 0 && in_span(ex, ey, px, py, qx, qy)))
      return CLS_TOUCH;
    return CLS_NONE;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic seg_pair_t make_pair(input int sx, sy, ex, ey, px, py, qx, qy);
    seg_pair_t p;
    p.first_start_x  = coord_t'(sx);
    p.first_start_y  = coord_t'(sy);
    p.first_end_x    = coord_t'(ex);
    p.first_end_y    = coord_t'(ey);
    p.second_start_x = coord_t'(px);
    p.second_start_y = coord_t'(py);
    p.second_end_x   = coord_t'(qx);
    p.second_end_y   = coord_t'(qy);
    return p;
  endfunction

  function automatic int rand_coord();
    return int'(coord_t'($urandom_range(0, 16'hFFFF)));
  endfunction

  // Offer one request after a random gap, hold it until accepted, then log
  // its expected class
  task automatic send_pair(input seg_pair_t p);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_seg_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_seg_bus.first_start_x  = p.first_start_x;
    in_seg_bus.first_start_y  = p.first_start_y;
    in_seg_bus.first_end_x    = p.first_end_x;
    in_seg_bus.first_end_y    = p.first_end_y;
    in_seg_bus.second_start_x = p.second_start_x;
    in_seg_bus.second_start_y = p.second_start_y;
    in_seg_bus.second_end_x   = p.second_end_x;
    in_seg_bus.second_end_y   = p.second_end_y;
    in_seg_bus.valid          = 1'b1;
    do @(posedge clk); while (!(in_seg_bus.valid === 1'b1 && in_seg_bus.ready === 1'b1));
    expected_class_q.push_back(classify_pair(p));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  task automatic test_extremes();
    // Diagonals of the full coordinate square cross at (-0.5, -0.5); the axes cross at the origin
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    // All endpoints at the same extreme corner
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    // Opposite edges of the square, parallel and apart
    send_pair(make_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
  endtask

  task automatic test_crossing_and_touch();
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
    // Shared endpoint
    send_pair(make_pair(0, 0, 5, 5, 5, 5, 9, 0));
    // Second segment starts on the interior of the first
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
    // First segment ends on the interior of the second
    send_pair(make_pair(5, 3, 5, 0, 0, 0, 10, 0));
    // Near miss just above the first segment
    send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 7));
  endtask

  task automatic test_collinear();
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(make_pair(0, 0, 4, 4, 6, 6, 9, 9));
    send_pair(make_pair(0, 0, 4, 0, 4, 0, 8, 0));
    send_pair(make_pair(-20, -20, 20, 20, -1, -1, 1, 1));
    send_pair(make_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
  endtask

  task automatic test_degenerate();
    // Point on, off, and on the line but past the end of the other segment
    send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
    send_pair(make_pair(3, 4, 3, 4, 0, 0, 6, 6));
    send_pair(make_pair(9, 9, 9, 9, 0, 0, 6, 6));
    // Two points, equal and distinct
    send_pair(make_pair(-7, 2, -7, 2, -7, 2, -7, 2));
    send_pair(make_pair(-7, 2, -7, 2, -7, 3, -7, 3));
    // Second segment is a point at an endpoint of the first
    send_pair(make_pair(-100, 50, 200, -25, 200, -25, 200, -25));
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  task automatic test_random_wide(input int count, input bit no_gaps);
    steady_flow = no_gaps;
    repeat (count)
      send_pair(make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord()));
    steady_flow = 1'b0;
  endtask

  // Tiny grid: dense in shared points, collinear and degenerate segments
  task automatic test_random_grid(input int count);
    int c[8];
    repeat (count) begin
      foreach (c[i]) c[i] = int'($urandom_range(0, 8)) - 4;
      send_pair(make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]));
    end
  endtask

  // All four endpoints on one line, base + t * direction
  task automatic test_random_collinear(input int count);
    int bx, by, dx, dy;
    int t[4];
    repeat (count) begin
      bx = int'($urandom_range(0, 20000)) - 10000;
      by = int'($urandom_range(0, 20000)) - 10000;
      dx = int'($urandom_range(0, 100)) - 50;
      dy = int'($urandom_range(0, 100)) - 50;
      foreach (t[i]) t[i] = int'($urandom_range(0, 16)) - 8;
      send_pair(make_pair(bx + t[0] * dx, by + t[0] * dy, bx + t[1] * dx, by + t[1] * dy,
                          bx + t[2] * dx, by + t[2] * dy, bx + t[3] * dx, by + t[3] * dy));
    end
  endtask

  // One endpoint placed exactly on the other segment, roles swapped at random
  task automatic test_random_touch(input int count);
    int sx, sy, dx, dy, m, k, qx, qy;
    seg_pair_t p;
    repeat (count) begin
      sx = int'($urandom_range(0, 20000)) - 10000;
      sy = int'($urandom_range(0, 20000)) - 10000;
      dx = int'($urandom_range(0, 100)) - 50;
      dy = int'($urandom_range(0, 100)) - 50;
      m  = $urandom_range(1, 100);
      k  = $urandom_range(0, m);
      qx = rand_coord();
      qy = rand_coord();
      if ($urandom_range(0, 1))
        p = make_pair(sx, sy, sx + m * dx, sy + m * dy, sx + k * dx, sy + k * dy, qx, qy);
      else
        p = make_pair(sx + k * dx, sy + k * dy, qx, qy, sx + m * dx, sy + m * dy, sx, sy);
      send_pair(p);
    end
  endtask

  // Coordinates drawn mostly from the ends and the middle of the range
  task automatic test_random_edges(input int count);
    int edge_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    int c[8];
    int pick;
    repeat (count) begin
      foreach (c[i]) begin
        pick = $urandom_range(0, 7);
        c[i] = (pick == 7) ? rand_coord() : edge_vals[pick];
      end
      send_pair(make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Stall the result channel a random number of cycles before each result
  initial begin
    int stall;
    out_seg_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_seg_bus.ready = 1'b0;
      end
      @(negedge clk);
      out_seg_bus.ready = 1'b1;
      do @(posedge clk); while (!(out_seg_bus.valid === 1'b1 && out_seg_bus.ready === 1'b1));
    end
  end

  // Compare each accepted result with the oldest expected class
  always @(posedge clk) begin
    cls_t want;
    if (rst_n && out_seg_bus.valid === 1'b1 && out_seg_bus.ready === 1'b1) begin
      if (expected_class_q.size() == 0) begin
        $error("unexpected result: crossing_class %0d", out_seg_bus.crossing_class);
        err_count++;
      end else begin
        want = expected_class_q.pop_front();
        if (out_seg_bus.crossing_class !== want) begin
          $error("crossing_class mismatch: expected %0d, actual %0d",
                 want, out_seg_bus.crossing_class);
          err_count++;
        end
      end
    end
  end

  // Abort when no request moves on either channel for too long
  always @(posedge clk) begin
    if ((in_seg_bus.valid === 1'b1 && in_seg_bus.ready === 1'b1) ||
        (out_seg_bus.valid === 1'b1 && out_seg_bus.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    err_count   = 0;
    idle_cycles = 0;
    steady_flow = 1'b0;
    rst_n       = 1'b0;
    in_seg_bus.valid          = 1'b0;
    in_seg_bus.first_start_x  = '0;
    in_seg_bus.first_start_y  = '0;
    in_seg_bus.first_end_x    = '0;
    in_seg_bus.first_end_y    = '0;
    in_seg_bus.second_start_x = '0;
    in_seg_bus.second_start_y = '0;
    in_seg_bus.second_end_x   = '0;
    in_seg_bus.second_end_y   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_crossing_and_touch();
    test_collinear();
    test_degenerate();
    test_random_wide(300, 1'b0);
    test_random_grid(450);
    test_random_collinear(300);
    test_random_touch(300);
    test_random_wide(150, 1'b1);
    test_random_edges(150);

    // Drop valid, drain the pipeline, then watch for stray results
    @(negedge clk);
    in_seg_bus.valid = 1'b0;
    waited = 0;
    while (expected_class_q.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_WAIT) @(posedge clk);

    if (expected_class_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_class_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/seg_pkg.sv
rtl/core/seg_if.sv
rtl/core/seg_diff.sv
rtl/core/seg_prod.sv
rtl/core/seg_sign.sv
rtl/core/segment_intersection_classifier.sv
bench/segment_intersection_classifier_tb.sv
